/* rtl/core/aip_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types, character codes and helpers for the ASCII integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_LO_X  = 8'h78;

  // Radix codes
  localparam logic [5:0] BASE_AUTO  = 6'd0;
  localparam logic [5:0] BASE_MIN   = 6'd2;
  localparam logic [5:0] BASE_OCT   = 6'd8;
  localparam logic [5:0] BASE_DEC   = 6'd10;
  localparam logic [5:0] BASE_HEX   = 6'd16;
  localparam logic [5:0] BASE_MAX   = 6'd36;
  localparam logic [5:0] DIGIT_NONE = 6'd36;
  localparam logic [5:0] LETTER_OFS = 6'hA;

  localparam logic [11:0] OFFSET_MAX = 12'hFFF;

  typedef enum logic [2:0] {
    PH_SPACE  = 3'd0,
    PH_SIGNED = 3'd1,
    PH_ZERO   = 3'd2,
    PH_XSEEN  = 3'd3,
    PH_DIGITS = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic        neg;
    logic [31:0] acc;
    logic [5:0]  base;
  } parse_st_t;

  typedef struct packed {
    logic        emit;
    logic [31:0] value;
    logic [11:0] offset;
    logic        by_char;
  } result_t;

  // Map a character to its digit value; DIGIT_NONE for anything else
  function automatic logic [5:0] digit_value(input logic [7:0] c);
    logic [7:0] diff;
    begin
      diff = 8'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        diff = c - CH_ZERO;
        return diff[5:0];
      end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
        diff = c - CH_UP_A;
        return diff[5:0] + LETTER_OFS;
      end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
        diff = c - CH_LO_A;
        return diff[5:0] + LETTER_OFS;
      end
      return DIGIT_NONE;
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/core/aip_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aip_in_if
// Character channel: one character and its end-of-buffer flag per beat.
// ----------------------------------------------------------------------------
interface aip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

/* rtl/core/aip_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aip_out_if
// Result channel: converted value, stop offset and stop reason per beat.
// ----------------------------------------------------------------------------
interface aip_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] parsed_value;
  logic [11:0]        stop_offset;
  logic               stopped_by_char;

  modport source (output valid, output parsed_value, output stop_offset,
                  output stopped_by_char, input ready);
  modport sink   (input valid, input parsed_value, input stop_offset,
                  input stopped_by_char, output ready);
endinterface
`default_nettype wire

/* rtl/core/aip_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aip_step
// Next-state and result logic for one character: phase decode, digit
// multiply-add and stop offset saturation.
// ----------------------------------------------------------------------------
module aip_step #(
  parameter int MAX_STRING_LEN = 4096
) (
  input  wire logic [5:0]                          cfg_base,
  input  wire aip_pkg::parse_st_t                  st,
  input  wire logic [$clog2(MAX_STRING_LEN)-1:0]   pos,
  input  wire logic [7:0]                          c,
  input  wire logic                                last,
  output aip_pkg::parse_st_t                       st_nxt,
  output logic [$clog2(MAX_STRING_LEN)-1:0]        pos_nxt,
  output aip_pkg::result_t                         res
);

  localparam int POS_W  = $clog2(MAX_STRING_LEN);
  localparam int OFF_W  = POS_W + 1;
  localparam int WIDE_W = OFF_W + 12;
  localparam logic [POS_W-1:0] POS_END = POS_W'(MAX_STRING_LEN - 1);

  logic [5:0]        d;
  logic [5:0]        b_cfg;
  logic [5:0]        eff;
  logic [5:0]        zbase;
  logic [5:0]        mul_base;
  logic [31:0]       mac;
  logic              hit_last;
  logic              go;
  logic              stop;
  logic [31:0]       stop_val;
  logic [OFF_W-1:0]  off_raw;
  logic              stop_by;
  logic [WIDE_W-1:0] off_wide;
  logic              is_x;

  // Decode the character and the radix in effect
  always_comb begin
    d        = aip_pkg::digit_value(c);
    b_cfg    = (cfg_base < aip_pkg::BASE_MIN || cfg_base > aip_pkg::BASE_MAX) ?
               aip_pkg::BASE_AUTO : cfg_base;
    eff      = (b_cfg == aip_pkg::BASE_AUTO) ? aip_pkg::BASE_DEC : b_cfg;
    zbase    = (st.base == aip_pkg::BASE_AUTO) ? aip_pkg::BASE_OCT : aip_pkg::BASE_HEX;
    mul_base = (st.phase == aip_pkg::PH_ZERO) ? zbase : st.base;
    mac      = st.acc * {26'd0, mul_base} + {26'd0, d};
    hit_last = last || (pos == POS_END);
    is_x     = (c == aip_pkg::CH_LO_X) || (c == aip_pkg::CH_UP_X);
  end

  // Advance the phase, or stop the number
  always_comb begin
    st_nxt   = st;
    pos_nxt  = pos + POS_W'(1);
    go       = 1'b0;
    stop     = 1'b0;
    stop_val = 32'd0;
    off_raw  = '0;
    stop_by  = 1'b0;

    case (st.phase)
      aip_pkg::PH_SPACE, aip_pkg::PH_SIGNED: begin
        if (st.phase == aip_pkg::PH_SPACE && c == aip_pkg::CH_SPACE) begin
          go = 1'b1;
        end else if (st.phase == aip_pkg::PH_SPACE &&
                     (c == aip_pkg::CH_MINUS || c == aip_pkg::CH_PLUS)) begin
          st_nxt.neg   = (c == aip_pkg::CH_MINUS);
          st_nxt.phase = aip_pkg::PH_SIGNED;
          go           = 1'b1;
        end else if (c == aip_pkg::CH_NUL) begin
          stop = 1'b1;
        end else if (c == aip_pkg::CH_ZERO &&
                     (b_cfg == aip_pkg::BASE_AUTO || b_cfg == aip_pkg::BASE_HEX)) begin
          st_nxt.base  = b_cfg;
          st_nxt.acc   = 32'd0;
          st_nxt.phase = aip_pkg::PH_ZERO;
          go           = 1'b1;
        end else if (d < eff) begin
          st_nxt.base  = eff;
          st_nxt.acc   = {26'd0, d};
          st_nxt.phase = aip_pkg::PH_DIGITS;
          go           = 1'b1;
        end else begin
          stop    = 1'b1;
          stop_by = 1'b1;
        end
      end
      aip_pkg::PH_ZERO: begin
        if (is_x) begin
          st_nxt.phase = aip_pkg::PH_XSEEN;
          go           = 1'b1;
        end else if (c == aip_pkg::CH_NUL) begin
          stop     = 1'b1;
          stop_val = st.acc;
          off_raw  = OFF_W'(pos);
        end else if (d < zbase) begin
          st_nxt.base  = zbase;
          st_nxt.acc   = mac;
          st_nxt.phase = aip_pkg::PH_DIGITS;
          go           = 1'b1;
        end else begin
          stop     = 1'b1;
          stop_val = st.acc;
          off_raw  = OFF_W'(pos);
          stop_by  = 1'b1;
        end
      end
      aip_pkg::PH_XSEEN: begin
        if (d < aip_pkg::BASE_HEX) begin
          st_nxt.base  = aip_pkg::BASE_HEX;
          st_nxt.acc   = {26'd0, d};
          st_nxt.phase = aip_pkg::PH_DIGITS;
          go           = 1'b1;
        end else begin
          // dangling prefix: point back at the x
          stop    = 1'b1;
          off_raw = OFF_W'(pos) - OFF_W'(1);
          stop_by = 1'b1;
        end
      end
      default: begin
        if (c == aip_pkg::CH_NUL) begin
          stop     = 1'b1;
          stop_val = st.acc;
          off_raw  = OFF_W'(pos);
        end else if (d < st.base) begin
          st_nxt.acc = mac;
          go         = 1'b1;
        end else begin
          stop     = 1'b1;
          stop_val = st.acc;
          off_raw  = OFF_W'(pos);
          stop_by  = 1'b1;
        end
      end
    endcase

    // End of buffer after a consumed character
    if (go && hit_last) begin
      stop = 1'b1;
      if (st_nxt.phase == aip_pkg::PH_DIGITS || st_nxt.phase == aip_pkg::PH_ZERO) begin
        stop_val = st_nxt.acc;
        off_raw  = OFF_W'(pos) + OFF_W'(1);
      end else if (st_nxt.phase == aip_pkg::PH_XSEEN) begin
        off_raw = OFF_W'(pos);
        stop_by = 1'b1;
      end
    end

    // Start over after a result
    if (stop) begin
      st_nxt.phase = aip_pkg::PH_SPACE;
      st_nxt.neg   = 1'b0;
      st_nxt.acc   = 32'd0;
      st_nxt.base  = aip_pkg::BASE_AUTO;
      pos_nxt      = '0;
    end
  end

  // Sign and saturate the result
  always_comb begin
    off_wide    = WIDE_W'(off_raw);
    res.emit    = stop;
    res.value   = st.neg ? (32'd0 - stop_val) : stop_val;
    res.offset  = (off_wide > WIDE_W'(aip_pkg::OFFSET_MAX)) ? aip_pkg::OFFSET_MAX :
                  off_wide[11:0];
    res.by_char = stop_by;
  end

endmodule
`default_nettype wire

/* rtl/core/ascii_integer_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Streaming string-to-integer converter, one character per beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one character per beat with a flag on the final character
//   of the buffer. out_ch carries one result per number: the signed value
//   (wrapped to 32 bits), the offset where conversion stopped and whether a
//   character stopped it. cfg_we/cfg_wdata set the radix (0 = auto), written
//   while the block is idle.
//   A beat is taken into an input register, then one pass of decode and a
//   32x6 multiply-add updates the parse state and, when the number ends,
//   loads the output register. The character that ends a number first sits
//   in the input register, then its result is loaded into the output
//   register; a stall on out_ch can hold it in between. Throughput is one
//   character per cycle while out_ch does not stall, set by the single multiply-add pass.
//   Reset clears the parse state, the radix (to auto) and both registers'
//   valid flags. When the receiver stalls, a pending result holds on out_ch;
//   the input register keeps one more character and in_ch.ready then drops
//   until the result is taken.
// ----------------------------------------------------------------------------
module ascii_integer_parser #(
  parameter int MAX_STRING_LEN = 4096
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [5:0] cfg_wdata,
  aip_in_if.sink          in_ch,
  aip_out_if.source       out_ch
);

  localparam int POS_W = $clog2(MAX_STRING_LEN);

  logic [5:0]          number_base_r;
  logic                in_valid_r;
  logic [7:0]          in_char_r;
  logic                in_last_r;
  aip_pkg::parse_st_t  st_r, st_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  aip_pkg::result_t    res;
  logic                fire;
  logic                out_valid_r;
  logic [31:0]         out_value_r;
  logic [11:0]         out_offset_r;
  logic                out_by_char_r;

  // Compute stage advances when the result slot is free or draining
  assign fire         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || fire;

  // Radix register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= aip_pkg::BASE_AUTO;
    end else if (cfg_we) begin
      number_base_r <= cfg_wdata;
    end
  end

  // Input register: hold a beat until the compute stage takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_char_r <= in_ch.char_code;
      in_last_r <= in_ch.last_char;
    end
  end

  aip_step #(
    .MAX_STRING_LEN (MAX_STRING_LEN)
  ) u_step (
    .cfg_base (number_base_r),
    .st       (st_r),
    .pos      (pos_r),
    .c        (in_char_r),
    .last     (in_last_r),
    .st_nxt   (st_nxt),
    .pos_nxt  (pos_nxt),
    .res      (res)
  );

  // Parse state: advance once per character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase <= aip_pkg::PH_SPACE;
      st_r.neg   <= 1'b0;
      st_r.acc   <= 32'd0;
      st_r.base  <= aip_pkg::BASE_AUTO;
      pos_r      <= '0;
    end else if (fire) begin
      st_r  <= st_nxt;
      pos_r <= pos_nxt;
    end
  end

  // Output register: load on a result, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.emit) begin
      out_value_r   <= res.value;
      out_offset_r  <= res.offset;
      out_by_char_r <= res.by_char;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.parsed_value    = out_value_r;
  assign out_ch.stop_offset     = out_offset_r;
  assign out_ch.stopped_by_char = out_by_char_r;

endmodule
`default_nettype wire

/* rtl/core/aip_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aip_checker
// Port-level checks for the ASCII integer parser, bound to the top level.
// ----------------------------------------------------------------------------
module aip_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_value,
  input wire logic [11:0] out_offset,
  input wire logic        out_by_char
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_offset) &&
                                $stable(out_by_char))
    else $error("result payload changed while stalled");

  // Backpressure only comes from a stalled result
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  // A stop at offset zero means no digits were taken
  a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_offset == 12'd0 |-> out_value == 32'd0)
    else $error("nonzero value with zero stop offset");

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ascii_integer_parser aip_checker u_aip_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_value   (out_ch.parsed_value),
  .out_offset  (out_ch.stop_offset),
  .out_by_char (out_ch.stopped_by_char)
);
`default_nettype wire
